// ===== hw/rtl/ilir_pkg.sv =====
package ilir_pkg;

	localparam int POS_W = 8;
	localparam int WORD_W = 32;
	localparam int LEN_W = 9;
	localparam int STATUS_W = 2;
	localparam int CMD_W = 3;

	localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]         cmd;
		logic [POS_W-1:0]         position;
		logic signed [WORD_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result_value;
		logic [LEN_W-1:0]         length;
		logic [STATUS_W-1:0]      status;
	} rsp_t;

endpackage

// ===== hw/rtl/ilir_ram.sv =====
module ilir_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/indexed_list_insert_remove.sv =====
// Ordered list of up to CAPACITY signed 32-bit words held in one RAM with a
// single write port and a single registered read port. Raise start for one
// cycle while busy is low; the command is taken at that edge and busy stays
// high until the result. The result is on result for exactly one cycle with
// done high, and cannot be held off, so capture it then; busy is already low
// in that cycle and the next command may be taken at its closing edge.
// After the decide state, with n the length before the command and p the
// position: append, write, unused codes and any rejected command finish in
// the decide state; read takes one RAM read; insert moves the n - p entries
// from p up one place and then writes the word; remove at index moves the
// n - 1 - p entries above p down; remove last only reads. Insert and remove
// move one entry per cycle through the RAM (read k, write its neighbor the next cycle),
// a rate set by that one write port. No clearing pass after reset: only entries below the length are ever read.
module indexed_list_insert_remove #(
	parameter int CAPACITY = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  ilir_pkg::req_t request,
	output logic           done,
	output ilir_pkg::rsp_t result
);

	import ilir_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam int SW = CW + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SHIFT_UP,
		S_PUT,
		S_TAKE,
		S_SHIFT_DN
	} state_t;

	state_t        state_q;
	req_t          req_q;
	rsp_t          rsp_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] k_q;
	logic          done_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic          in_range;
	logic          full;
	logic          up_more;
	logic          next1_in;
	logic          next2_in;
	logic [AW-1:0] pos_a;
	logic [AW-1:0] k_a;

	// index checks against the current length
	assign in_range = PW'(req_q.position) < PW'(count_q);
	assign full     = count_q == CW'(CAPACITY);
	assign pos_a    = AW'(req_q.position);
	assign k_a      = k_q[AW-1:0];
	// shift up continues while the slot below the destination is above the position
	assign up_more  = (k_q - CW'(1)) != CW'(req_q.position);
	assign next1_in = (SW'(k_q) + SW'(1)) < SW'(count_q);
	assign next2_in = (SW'(k_q) + SW'(2)) < SW'(count_q);

	// RAM port control: one read and one write per cycle
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_a;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = k_a;
		unique case (state_q)
			S_DECIDE: begin
				unique case (req_q.cmd) inside
					CMD_APPEND: begin
						if (!full) begin
							ram_we    = 1'b1;
							ram_waddr = count_q[AW-1:0];
							ram_wdata = req_q.value;
						end
					end
					CMD_INSERT: begin
						// fetch the last entry to start the upward move
						if (in_range && !full) begin
							ram_re    = 1'b1;
							ram_raddr = AW'(count_q - CW'(1));
						end
					end
					CMD_REMOVE, CMD_READ: begin
						if (in_range) begin
							ram_re    = 1'b1;
							ram_raddr = pos_a;
						end
					end
					CMD_POP: begin
						if (count_q != '0) begin
							ram_re    = 1'b1;
							ram_raddr = AW'(count_q - CW'(1));
						end
					end
					CMD_WRITE: begin
						if (in_range) begin
							ram_we    = 1'b1;
							ram_waddr = pos_a;
							ram_wdata = req_q.value;
						end
					end
					default: begin
					end
				endcase
			end
			S_SHIFT_UP: begin
				// write the entry fetched last cycle one place up, fetch the next lower one
				ram_we    = 1'b1;
				ram_waddr = k_a;
				ram_wdata = ram_rdata;
				if (up_more) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(k_q - CW'(2));
				end
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_a;
				ram_wdata = req_q.value;
			end
			S_TAKE: begin
				if (next1_in) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(k_q + CW'(1));
				end
			end
			S_SHIFT_DN: begin
				// write the entry fetched last cycle one place down, fetch the next higher one
				ram_we    = 1'b1;
				ram_waddr = k_a;
				ram_wdata = ram_rdata;
				if (next2_in) begin
					ram_re    = 1'b1;
					ram_raddr = AW'(k_q + CW'(2));
				end
			end
			default: begin
			end
		endcase
	end

	ilir_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer, length register and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			k_q     <= '0;
			req_q   <= '0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					// take the command transfer
					if (start) begin
						req_q   <= request;
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					rsp_q.result_value <= '0;
					rsp_q.length       <= LEN_W'(count_q);
					rsp_q.status       <= ST_OK;
					unique case (req_q.cmd) inside
						CMD_APPEND: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							if (full) begin
								rsp_q.status <= ST_FULL;
							end else begin
								count_q      <= count_q + CW'(1);
								rsp_q.length <= LEN_W'(count_q + CW'(1));
							end
						end
						CMD_INSERT: begin
							if (!in_range) begin
								rsp_q.status <= ST_RANGE;
								done_q       <= 1'b1;
								state_q      <= S_IDLE;
							end else if (full) begin
								rsp_q.status <= ST_FULL;
								done_q       <= 1'b1;
								state_q      <= S_IDLE;
							end else begin
								k_q     <= count_q;
								state_q <= S_SHIFT_UP;
							end
						end
						CMD_REMOVE, CMD_READ: begin
							if (!in_range) begin
								rsp_q.status <= ST_RANGE;
								done_q       <= 1'b1;
								state_q      <= S_IDLE;
							end else begin
								k_q     <= CW'(req_q.position);
								state_q <= S_TAKE;
							end
						end
						CMD_POP: begin
							if (count_q == '0) begin
								rsp_q.status <= ST_RANGE;
								done_q       <= 1'b1;
								state_q      <= S_IDLE;
							end else begin
								k_q     <= count_q - CW'(1);
								state_q <= S_TAKE;
							end
						end
						CMD_WRITE: begin
							if (!in_range) begin
								rsp_q.status <= ST_RANGE;
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						default: begin
							// unused codes: no operation
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_SHIFT_UP: begin
					if (up_more) begin
						k_q <= k_q - CW'(1);
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q      <= count_q + CW'(1);
					rsp_q.length <= LEN_W'(count_q + CW'(1));
					done_q       <= 1'b1;
					state_q      <= S_IDLE;
				end
				S_TAKE: begin
					// hold the removed or read word until the strobe
					rsp_q.result_value <= ram_rdata;
					if (req_q.cmd == CMD_READ) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (next1_in) begin
						state_q <= S_SHIFT_DN;
					end else begin
						count_q      <= count_q - CW'(1);
						rsp_q.length <= LEN_W'(count_q - CW'(1));
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				S_SHIFT_DN: begin
					k_q <= k_q + CW'(1);
					if (!next2_in) begin
						count_q      <= count_q - CW'(1);
						rsp_q.length <= LEN_W'(count_q - CW'(1));
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = rsp_q;

	// a result never appears while a command is still being worked on
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the length never passes the capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(count_q) <= SW'(CAPACITY))
		else $error("length beyond capacity");

	// work starts only from an accepted command transfer
	a_busy_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy without a command");

	// a full report only when the list really is full
	a_full_report: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> full)
		else $error("full reported on a list with room");

	// the RAM is written only while a command is in progress
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> busy)
		else $error("RAM write while idle");

	// the length moves by at most one per command, and only at its end
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> done)
		else $error("length changed outside a result");

endmodule

// ===== sim/ilir_checker.sv =====
`timescale 1ns / 1ps
module ilir_checker #(
	parameter int CAPACITY = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  ilir_pkg::req_t request,
	input  logic           done,
	input  ilir_pkg::rsp_t result,
	output int             errors,
	output int             replies_owed,
	output int             replies_seen
);
	import ilir_pkg::*;

	// shadow copy of the list contents and fill level
	logic signed [WORD_W-1:0] shadow_words [CAPACITY];
	int                       shadow_len = 0;

	rsp_t replies_due [$];
	rsp_t want_rsp;
	rsp_t next_rsp;
	int   mismatch_count = 0;
	int   seen_count = 0;

	// drop one entry and close the gap above it
	function automatic logic signed [WORD_W-1:0] take_word(input int at);
		logic signed [WORD_W-1:0] word;
		int k;
		word = shadow_words[at];
		for (k = at; k + 1 < shadow_len; k++)
			shadow_words[k] = shadow_words[k + 1];
		shadow_len--;
		return word;
	endfunction

	task automatic apply_list_command(input req_t item, output rsp_t reply);
		int at;
		int k;
		logic in_range;
		reply = '0;
		at = int'(item.position);
		in_range = (at < shadow_len);
		case (item.cmd)
			CMD_APPEND: begin
				if (shadow_len >= CAPACITY) begin
					reply.status = ST_FULL;
				end else begin
					shadow_words[shadow_len] = item.value;
					shadow_len++;
				end
			end
			CMD_INSERT: begin
				// index test wins over the full test
				if (!in_range) begin
					reply.status = ST_RANGE;
				end else if (shadow_len >= CAPACITY) begin
					reply.status = ST_FULL;
				end else begin
					for (k = shadow_len; k > at; k--)
						shadow_words[k] = shadow_words[k - 1];
					shadow_words[at] = item.value;
					shadow_len++;
				end
			end
			CMD_REMOVE: begin
				if (!in_range)
					reply.status = ST_RANGE;
				else
					reply.result_value = take_word(at);
			end
			CMD_POP: begin
				if (shadow_len == 0)
					reply.status = ST_RANGE;
				else
					reply.result_value = take_word(shadow_len - 1);
			end
			CMD_READ: begin
				if (!in_range)
					reply.status = ST_RANGE;
				else
					reply.result_value = shadow_words[at];
			end
			CMD_WRITE: begin
				if (!in_range)
					reply.status = ST_RANGE;
				else
					shadow_words[at] = item.value;
			end
			default: begin
			end
		endcase
		reply.length = LEN_W'(shadow_len);
	endtask

	task automatic flag_field(input string field, input logic signed [63:0] want,
			input logic signed [63:0] got);
		mismatch_count++;
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_len = 0;
			replies_due.delete();
			mismatch_count = 0;
			seen_count = 0;
		end else begin
			// a result and the next command can share one edge: retire first
			if (done) begin
				seen_count++;
				if (replies_due.size() == 0) begin
					mismatch_count++;
					$display(
						"%0t ns: expected no result, got value %0d length %0d status %0d",
						$time, result.result_value, result.length, result.status);
				end else begin
					want_rsp = replies_due.pop_front();
					if (result.result_value !== want_rsp.result_value)
						flag_field("result_value", 64'(want_rsp.result_value),
							64'(result.result_value));
					if (result.length !== want_rsp.length)
						flag_field("length", 64'(want_rsp.length), 64'(result.length));
					if (result.status !== want_rsp.status)
						flag_field("status", 64'(want_rsp.status), 64'(result.status));
				end
			end
			if (start && !busy) begin
				apply_list_command(request, next_rsp);
				replies_due.push_back(next_rsp);
			end
		end
		errors <= mismatch_count;
		replies_owed <= replies_due.size();
		replies_seen <= seen_count;
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import ilir_pkg::*;

	localparam int LIST_DEPTH = 256;
	localparam int RANDOM_ITEMS = 1500;
	// longest legal silence is one full-length shift plus a sender gap;
	// allow many times that before calling the block hung
	localparam int QUIET_LIMIT = 4000;
	// after the last result, keep watching long enough for a stray one
	localparam int DRAIN_CYCLES = LIST_DEPTH + 16;
	// command codes with no operation behind them
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	// flavors of random traffic; each burst pushes the fill level a certain way
	typedef enum int {
		MIX_FILL,
		MIX_GROW,
		MIX_SHRINK,
		MIX_DRAIN,
		MIX_BLEND
	} mix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	int errors;
	int replies_owed;
	int replies_seen;

	int quiet_cycles = 0;
	int idle_pct = 36;
	// running fill level, used only to aim positions and bursts
	int track_len = 0;
	int peak_len = 0;
	int full_pushes = 0;
	int sent = 0;

	always #5 clk = ~clk;

	indexed_list_insert_remove #(
		.CAPACITY(LIST_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.request(request),
		.done   (done),
		.result (result)
	);

	ilir_checker #(
		.CAPACITY(LIST_DEPTH)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.result      (result),
		.errors      (errors),
		.replies_owed(replies_owed),
		.replies_seen(replies_seen)
	);

	// Watchdog: count edges with neither a command transfer nor a result.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no transfer for %0d cycles, giving up", $time, quiet_cycles);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	function automatic req_t make_req(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] position, input logic signed [WORD_W-1:0] value);
		req_t item;
		item.cmd = cmd;
		item.position = position;
		item.value = value;
		return item;
	endfunction

	// Aim mostly at live entries, with the ends weighted up so the longest
	// shifts happen often; the rest goes past the end.
	function automatic logic [POS_W-1:0] pick_position(input int n);
		int roll;
		roll = $urandom_range(99);
		if (n == 0)
			return POS_W'($urandom_range(LIST_DEPTH - 1));
		if (roll < 12 && n < LIST_DEPTH)
			return POS_W'($urandom_range(LIST_DEPTH - 1, n));
		if (roll < 30)
			return '0;
		if (roll < 48)
			return POS_W'(n - 1);
		return POS_W'($urandom_range(n - 1, 0));
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(99);
		if (roll < 10)
			return 32'sh8000_0000;
		if (roll < 20)
			return 32'sh7fff_ffff;
		if (roll < 25)
			return -32'sd1;
		if (roll < 30)
			return 32'sd0;
		return $urandom;
	endfunction

	function automatic req_t pick_command(input mix_t mix, input int n);
		req_t item;
		int roll;
		roll = $urandom_range(99);
		item.position = pick_position(n);
		item.value = pick_value();
		if ($urandom_range(99) < 3) begin
			// unused codes: must answer as a no-op
			item.cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
		end else begin
			case (mix)
				MIX_FILL: begin
					item.cmd = (roll < 60) ? CMD_APPEND : (roll < 92) ? CMD_INSERT :
						CMD_READ;
				end
				MIX_GROW: begin
					item.cmd = (roll < 40) ? CMD_APPEND : (roll < 65) ? CMD_INSERT :
						(roll < 75) ? CMD_REMOVE : (roll < 80) ? CMD_POP :
						(roll < 90) ? CMD_READ : CMD_WRITE;
				end
				MIX_SHRINK: begin
					item.cmd = (roll < 10) ? CMD_APPEND : (roll < 20) ? CMD_INSERT :
						(roll < 55) ? CMD_REMOVE : (roll < 80) ? CMD_POP :
						(roll < 90) ? CMD_READ : CMD_WRITE;
				end
				MIX_DRAIN: begin
					item.cmd = (roll < 50) ? CMD_REMOVE : (roll < 90) ? CMD_POP :
						(roll < 95) ? CMD_READ : CMD_APPEND;
				end
				default: begin
					item.cmd = (roll < 20) ? CMD_APPEND : (roll < 40) ? CMD_INSERT :
						(roll < 55) ? CMD_REMOVE : (roll < 65) ? CMD_POP :
						(roll < 82) ? CMD_READ : CMD_WRITE;
				end
			endcase
		end
		return item;
	endfunction

	// Present one command and hold it until the transfer. Idle first at the
	// current rate, putting junk on the request bus while start is low.
	task automatic push_command(input req_t item);
		req_t junk;
		while ($urandom_range(99) < idle_pct) begin
			junk.cmd = CMD_W'($urandom_range(CMD_SPARE_HI));
			junk.position = POS_W'($urandom_range(LIST_DEPTH - 1));
			junk.value = $urandom;
			start <= 1'b0;
			request <= junk;
			@(posedge clk);
		end
		start <= 1'b1;
		request <= item;
		@(posedge clk);
		// busy sampled here is its value before this edge
		while (busy)
			@(posedge clk);
		sent++;
		if ((item.cmd == CMD_APPEND || item.cmd == CMD_INSERT) && track_len == LIST_DEPTH)
			full_pushes++;
		case (item.cmd)
			CMD_APPEND: if (track_len < LIST_DEPTH) track_len++;
			CMD_INSERT: if (item.position < track_len && track_len < LIST_DEPTH) track_len++;
			CMD_REMOVE: if (item.position < track_len) track_len--;
			CMD_POP:    if (track_len > 0) track_len--;
			default: begin
			end
		endcase
		if (track_len > peak_len)
			peak_len = track_len;
	endtask

	initial begin : stimulus
		int phase;
		int phase_items;
		int burst;
		int k;
		mix_t mix;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 36;

		// Every indexed command on an empty list, plus remove last: all out of range.
		push_command(make_req(CMD_READ, 8'd0, 32'sd0));
		push_command(make_req(CMD_WRITE, 8'd0, 32'sd99));
		push_command(make_req(CMD_REMOVE, 8'd0, 32'sd0));
		push_command(make_req(CMD_POP, 8'd0, 32'sd0));
		push_command(make_req(CMD_INSERT, 8'd0, 32'sd5));
		// Unused codes answer as no-ops.
		push_command(make_req(CMD_SPARE_LO, 8'd0, 32'sd0));
		push_command(make_req(CMD_SPARE_HI, 8'hff, -32'sd1));
		// Extremes of the word through append.
		push_command(make_req(CMD_APPEND, 8'hff, 32'sh7fff_ffff));
		push_command(make_req(CMD_APPEND, 8'd0, 32'sh8000_0000));
		push_command(make_req(CMD_APPEND, 8'h55, -32'sd1));
		push_command(make_req(CMD_APPEND, 8'haa, 32'sd0));
		// Insert at the head and in the middle.
		push_command(make_req(CMD_INSERT, 8'd0, 32'sd12345));
		push_command(make_req(CMD_INSERT, 8'd2, -32'sd77));
		// Read just past the end and at the top of the index field.
		push_command(make_req(CMD_READ, 8'd6, 32'sd0));
		push_command(make_req(CMD_READ, 8'hff, 32'sd0));
		push_command(make_req(CMD_READ, 8'd1, 32'sd0));
		// Overwrite the last entry and read it back.
		push_command(make_req(CMD_WRITE, 8'd5, 32'sh55aa_55aa));
		push_command(make_req(CMD_READ, 8'd5, 32'sd0));
		// Remove at the head, at the last index, then remove last.
		push_command(make_req(CMD_REMOVE, 8'd0, 32'sd0));
		push_command(make_req(CMD_REMOVE, 8'd4, 32'sd0));
		push_command(make_req(CMD_POP, 8'd0, 32'sd0));
		// Insert in front of the last entry, then check the survivors.
		push_command(make_req(CMD_INSERT, 8'd2, 32'sh0bad_f00d));
		push_command(make_req(CMD_READ, 8'd0, 32'sd0));
		push_command(make_req(CMD_READ, 8'd2, 32'sd0));

		// Random bursts under three idle profiles. Each profile opens with a
		// fill so the full-list cases and the longest shifts get exercised.
		for (phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 36 : (phase == 1) ? 71 : 0;
			phase_items = 0;
			while (phase_items < RANDOM_ITEMS / 3) begin
				mix = (phase_items == 0) ? MIX_FILL : mix_t'($urandom_range(4));
				case (mix)
					MIX_FILL:  burst = LIST_DEPTH - track_len + $urandom_range(30, 5);
					MIX_DRAIN: burst = track_len + $urandom_range(12, 3);
					default:   burst = $urandom_range(120, 10);
				endcase
				for (k = 0; k < burst && phase_items < RANDOM_ITEMS / 3; k++) begin
					push_command(pick_command(mix, track_len));
					phase_items++;
				end
			end
		end

		// Release start right after the last transfer, then let results drain.
		start <= 1'b0;
		@(posedge clk);
		while (replies_owed != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d directed and random commands under three idle profiles",
			sent);
		$display("%0d results checked, fill peaked at %0d, %0d pushes met a full list",
			replies_seen, peak_len, full_pushes);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ilir_pkg.sv
hw/rtl/ilir_ram.sv
hw/rtl/indexed_list_insert_remove.sv
sim/ilir_checker.sv
sim/tb.sv
